>>> rtl/crt_pkg.sv
`timescale 1ns / 1ps

package crt_pkg;

  // Special characters
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Request opcodes
  localparam logic OpData = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_FIELD    = 3'd1,
    KIND_FIELDREC = 3'd2,
    KIND_RECONLY  = 3'd3,
    KIND_DROP     = 3'd4
  } kind_e;

  // One result
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        last;
  } res_t;

  // Up to two results produced by one request
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Result queue depth; must hold two pushes ahead of one pop
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

>>> rtl/crt_in_if.sv
`timescale 1ns / 1ps

interface crt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink (input valid, input op, input in_byte, output ready);
endinterface

>>> rtl/crt_out_if.sv
`timescale 1ns / 1ps

interface crt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

>>> rtl/csv_record_tokenizer.sv
`timescale 1ns / 1ps

// CSV record tokenizer. Each request is one input byte or an end-of-input
// mark; each result is a field data byte, a field end, a field-and-record
// end, a record end with no field, or a record-dropped mark, with last set
// on the final result of a request. A request passes through an input
// register and the decode logic into a four-entry result queue, so one
// request is taken per cycle as long as the consumer drains one result per
// cycle. Requests are held off while the queue has fewer than two free
// entries; a lone CR followed by another byte gives two results for that
// byte. Requests that give no result (an opening or closing quote, a CR)
// still pass through the input register and the decode logic.

module csv_record_tokenizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  crt_in_if.sink    in_i,
  crt_out_if.source out_o
);
  import crt_pkg::*;

  push_t push;
  logic  room;
  res_t  res;

  // Tokenizer state machine with input register
  crt_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (in_i.op),
    .in_byte_i  (in_i.in_byte),
    .in_ready_o (in_i.ready),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue
  crt_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.kind     = res.kind;
  assign out_o.out_byte = res.out_byte;
  assign out_o.last     = res.last;

endmodule

>>> rtl/crt_fsm.sv
`timescale 1ns / 1ps

module crt_fsm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          op_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  input  logic          room_i,
  output crt_pkg::push_t push_o
);
  import crt_pkg::*;

  typedef enum logic [2:0] {
    ST_BETWEEN = 3'd0,
    ST_PLAIN   = 3'd1,
    ST_QUOTED  = 3'd2,
    ST_AFTERQ  = 3'd3,
    ST_AFTERCR = 3'd4
  } state_e;

  logic       valid_q, valid_d;
  logic       op_q;
  logic [7:0] byte_q;
  state_e     state_q, state_d;
  logic       nonempty_q, nonempty_d;
  logic       fire;
  logic       accept;
  push_t      push;

  // Input register: refills in the same cycle it is consumed
  assign fire       = valid_q && room_i;
  assign in_ready_o = !valid_q || room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign valid_d    = accept ? 1'b1 : (fire ? 1'b0 : valid_q);

  // Tokenizer decode
  always_comb begin
    state_d    = state_q;
    nonempty_d = nonempty_q;
    push       = '0;
    if (op_q == OpEnd) begin
      push.cnt   = 2'd1;
      state_d    = ST_BETWEEN;
      nonempty_d = 1'b0;
      if (state_q == ST_PLAIN || state_q == ST_QUOTED || state_q == ST_AFTERQ ||
          state_q == ST_AFTERCR) begin
        push.r0.kind = nonempty_q ? KIND_FIELDREC : KIND_RECONLY;
      end else begin
        push.r0.kind = KIND_DROP;
      end
    end else begin
      unique case (state_q)
        ST_QUOTED: begin
          if (byte_q == ChQuote) begin
            state_d = ST_AFTERQ;
          end else begin
            push.cnt         = 2'd1;
            push.r0.kind     = KIND_DATA;
            push.r0.out_byte = byte_q;
            nonempty_d       = 1'b1;
          end
        end
        ST_AFTERCR: begin
          if (byte_q == ChLf) begin
            push.cnt     = 2'd1;
            push.r0.kind = KIND_FIELDREC;
            state_d      = ST_BETWEEN;
            nonempty_d   = 1'b0;
          end else begin
            // lone CR: emit it, then the byte, as plain field data
            push.cnt         = 2'd2;
            push.r0.kind     = KIND_DATA;
            push.r0.out_byte = ChCr;
            push.r1.kind     = KIND_DATA;
            push.r1.out_byte = byte_q;
            state_d          = ST_PLAIN;
            nonempty_d       = 1'b1;
          end
        end
        default: begin
          // between fields, plain field, after closing quote
          if (byte_q == ChComma) begin
            push.cnt     = 2'd1;
            push.r0.kind = KIND_FIELD;
            state_d      = ST_BETWEEN;
            nonempty_d   = 1'b0;
          end else if (byte_q == ChCr) begin
            state_d = ST_AFTERCR;
          end else if (byte_q == ChLf) begin
            push.cnt     = 2'd1;
            push.r0.kind = KIND_FIELDREC;
            state_d      = ST_BETWEEN;
            nonempty_d   = 1'b0;
          end else if (state_q != ST_PLAIN && state_q != ST_AFTERQ && byte_q == ChQuote) begin
            state_d = ST_QUOTED;
          end else begin
            push.cnt         = 2'd1;
            push.r0.kind     = KIND_DATA;
            push.r0.out_byte = byte_q;
            nonempty_d       = 1'b1;
            state_d          = (state_q == ST_AFTERQ) ? ST_QUOTED : ST_PLAIN;
          end
        end
      endcase
    end
    // mark the final result of this request
    if (push.cnt == 2'd2) begin
      push.r1.last = 1'b1;
    end else begin
      push.r0.last = 1'b1;
    end
    if (!fire) begin
      push.cnt = 2'd0;
    end
  end

  assign push_o = push;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      state_q    <= ST_BETWEEN;
      nonempty_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (fire) begin
        state_q    <= state_d;
        nonempty_q <= nonempty_d;
      end
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      byte_q <= in_byte_i;
    end
  end

endmodule

>>> rtl/crt_res_fifo.sv
`timescale 1ns / 1ps

module crt_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crt_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output crt_pkg::res_t  out_res_o
);
  import crt_pkg::*;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wr_next;

  // Room for a worst-case push of two results
  assign room_o      = cnt_q <= QCntW'(QDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_next     = wr_q + QPtrW'(1);
  assign cnt_d       = cnt_q + QCntW'(push_i.cnt) - QCntW'(pop);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.cnt);
      cnt_q <= cnt_d;
      if (pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

endmodule

>>> verif/tb_csv_record_tokenizer.sv
`timescale 1ns / 1ps

module tb_csv_record_tokenizer;
  import crt_pkg::*;

  // Parser states as the predictor tracks them
  typedef enum logic [2:0] {
    PS_BETWEEN = 3'd0,
    PS_PLAIN   = 3'd1,
    PS_QUOTED  = 3'd2,
    PS_AFTERQ  = 3'd3,
    PS_AFTERCR = 3'd4
  } ps_e;

  logic clk_i;
  logic rst_ni;

  crt_in_if  in_if ();
  crt_out_if out_if ();

  csv_record_tokenizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state and expected tokens
  ps_e  pstate;
  logic field_has_bytes;
  res_t step_q[$];
  res_t token_q[$];

  // Idling knobs, long receiver hold-off
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;

  // Run statistics
  int unsigned n_requests;
  int unsigned n_tokens;
  int unsigned n_records;
  int unsigned n_mismatch;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #400_000;
    $display("tb: failure");
    $finish;
  end

  // Predictor: add one token to the tokens of the current request
  function automatic void queue_step(res_t r);
    step_q = {step_q, r};
  endfunction

  // Predictor: append one data token
  function automatic void emit_data(logic [7:0] c);
    field_has_bytes = 1'b1;
    queue_step('{kind: KIND_DATA, out_byte: c, last: 1'b0});
  endfunction

  // Predictor: append an end mark and go back between fields
  function automatic void emit_end(kind_e k);
    field_has_bytes = 1'b0;
    pstate          = PS_BETWEEN;
    queue_step('{kind: k, out_byte: 8'h00, last: 1'b0});
  endfunction

  // Predict the tokens caused by one accepted request
  function automatic void predict_tokens(logic op, logic [7:0] c);
    step_q.delete();
    if (op == OpEnd) begin
      if (pstate == PS_BETWEEN) emit_end(KIND_DROP);
      else if (field_has_bytes) emit_end(KIND_FIELDREC);
      else                      emit_end(KIND_RECONLY);
    end else begin
      case (pstate)
        PS_QUOTED: begin
          if (c == ChQuote) pstate = PS_AFTERQ;
          else              emit_data(c);
        end
        PS_AFTERCR: begin
          if (c == ChLf) begin
            emit_end(KIND_FIELDREC);
          end else begin
            // lone CR: both bytes become data of a plain field
            emit_data(ChCr);
            emit_data(c);
            pstate = PS_PLAIN;
          end
        end
        default: begin
          if (c == ChComma)                              emit_end(KIND_FIELD);
          else if (c == ChCr)                            pstate = PS_AFTERCR;
          else if (c == ChLf)                            emit_end(KIND_FIELDREC);
          else if (pstate == PS_BETWEEN && c == ChQuote) pstate = PS_QUOTED;
          else begin
            emit_data(c);
            pstate = (pstate == PS_AFTERQ) ? PS_QUOTED : PS_PLAIN;
          end
        end
      endcase
    end
    if (step_q.size() != 0) step_q[$].last = 1'b1;
    token_q = {token_q, step_q};
  endfunction

  // Send one request; called and returns at a rising edge
  task automatic send_request(input logic op, input logic [7:0] b);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.in_byte <= b;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
    predict_tokens(op, b);
    n_requests++;
  endtask

  // Pause the sender until every expected token has come
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Bytes with the special characters weighted up
  function automatic logic [7:0] any_byte();
    case ($urandom_range(9))
      0:       return ChQuote;
      1:       return ChComma;
      2:       return ChCr;
      3:       return ChLf;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Byte that can stand in a plain field
  function automatic logic [7:0] plain_byte(bit first);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == ChComma || b == ChCr || b == ChLf || (first && b == ChQuote));
    return b;
  endfunction

  // One well-formed record with random content
  task automatic send_record();
    int unsigned nf;
    int unsigned len;
    logic [7:0]  b;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) send_request(OpData, ChComma);
      if ($urandom_range(2) == 0) begin
        send_request(OpData, ChQuote);
        len = $urandom_range(0, 5);
        for (int i = 0; i < len; i++) begin
          b = any_byte();
          send_request(OpData, b);
          if (b == ChQuote) send_request(OpData, ChQuote);
        end
        send_request(OpData, ChQuote);
      end else begin
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) send_request(OpData, plain_byte(i == 0));
      end
    end
    case ($urandom_range(7))
      0:       send_request(OpEnd, 8'($urandom_range(255)));
      1, 2, 3: send_request(OpData, ChLf);
      default: begin
        send_request(OpData, ChCr);
        send_request(OpData, ChLf);
      end
    endcase
  endtask

  // Raw noise, end-of-input marks included
  task automatic send_noise(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) send_request(OpEnd, 8'($urandom_range(255)));
      else                         send_request(OpData, any_byte());
    end
  endtask

  // Extremes and the main special cases, no idling
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(OpEnd,  8'hA5);    // end with nothing sent: drop
    send_request(OpEnd,  8'hFF);    // repeated end: drop again
    send_request(OpData, 8'h00);
    send_request(OpData, 8'hFF);
    send_request(OpData, ChQuote);  // quote inside a plain field is data
    send_request(OpData, ChComma);
    send_request(OpData, ChQuote);  // opening quote
    send_request(OpData, ChComma);  // comma inside quotes
    send_request(OpData, ChLf);     // LF inside quotes
    send_request(OpData, ChQuote);
    send_request(OpData, ChQuote);  // escaped quote
    send_request(OpData, ChQuote);
    send_request(OpData, 8'h78);    // byte after closing quote resumes the field
    send_request(OpData, ChQuote);
    send_request(OpData, ChCr);
    send_request(OpData, ChLf);     // CR LF after closing quote
    send_request(OpData, ChCr);
    send_request(OpData, ChComma);  // lone CR then comma: two data bytes
    send_request(OpData, ChCr);
    send_request(OpData, ChCr);     // CR then CR
    send_request(OpEnd,  8'h00);    // end in a non-empty field
    send_request(OpData, ChComma);  // empty field
    send_request(OpData, ChLf);     // LF between fields
    send_request(OpData, ChQuote);
    send_request(OpEnd,  8'h5A);    // end in an empty quoted field
    wait_idle();
  endtask

  // Mostly well-formed records, some noise, under one idling mix
  task automatic test_random_stream(input int unsigned idle, input int unsigned stall,
                                    input int unsigned n);
    int unsigned start;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    start          = n_requests;
    while (n_requests - start < n) begin
      if ($urandom_range(4) == 0) send_noise($urandom_range(1, 6));
      else                        send_record();
    end
    wait_idle();
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 80;
    repeat (6) send_record();
    wait_idle();
  endtask

  // Sender pauses until drained between records
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 14;
    repeat (5) begin
      send_record();
      wait_idle();
    end
  endtask

  // Receiver ready: random stalls plus the long hold-off
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic void note_mismatch(string what, res_t exp);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch %s: exp kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
               what, exp.kind, exp.out_byte, exp.last,
               out_if.kind, out_if.out_byte, out_if.last);
  endfunction

  // Check each token taken by the receiver against the oldest prediction
  always @(negedge clk_i) begin
    res_t exp;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (token_q.size() == 0) begin
        note_mismatch("unexpected token", '{kind: KIND_DATA, out_byte: 8'h00, last: 1'b0});
      end else begin
        exp = token_q.pop_front();
        n_tokens++;
        if (exp.kind == KIND_FIELDREC || exp.kind == KIND_RECONLY) n_records++;
        if (out_if.kind !== exp.kind || out_if.out_byte !== exp.out_byte ||
            out_if.last !== exp.last)
          note_mismatch("wrong token", exp);
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OpData;
    in_if.in_byte   = 8'h00;
    pstate          = PS_BETWEEN;
    field_has_bytes = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 0;
    n_requests      = 0;
    n_tokens        = 0;
    n_records       = 0;
    n_mismatch      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_stream(0, 0, 250);
    test_random_stream(54, 0, 250);
    test_random_stream(0, 54, 250);
    test_random_stream(14, 14, 250);
    test_backpressure();
    test_drain_pause();

    while (token_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (token_q.size() != 0) n_mismatch++;

    $display("summary: %0d requests over four idling mixes and a long hold-off,",
             n_requests);
    $display("summary: %0d tokens checked, %0d records closed, %0d mismatches",
             n_tokens, n_records, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
